[design/wsd_pkg.sv]
// Shared types and constants for the websocket frame deframer.
`default_nettype none
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned LenW    = 64;
  localparam int unsigned LenCntW = 4;
  localparam int unsigned SkipW   = 2;

  // Header constants
  localparam logic [6:0]     Len7Ext16 = 7'd126;
  localparam logic [6:0]     Len7Ext64 = 7'd127;
  localparam logic [LenCntW-1:0] ExtBytes16 = 4'd2;
  localparam logic [LenCntW-1:0] ExtBytes64 = 4'd8;
  localparam logic [SkipW-1:0]   StatusBytes = 2'd2;

  typedef enum logic [OpW-1:0] {
    OP_CONT   = 4'd0,
    OP_TEXT   = 4'd1,
    OP_BINARY = 4'd2,
    OP_CLOSE  = 4'd8,
    OP_PING   = 4'd9,
    OP_PONG   = 4'd10
  } opcode_t;

  typedef enum logic [2:0] {
    EV_DATA   = 3'd0,
    EV_EMPTY  = 3'd1,
    EV_CLOSED = 3'd2,
    EV_MASKED = 3'd3,
    EV_BADOP  = 3'd4
  } event_t;

  typedef struct packed {
    logic             valid;
    event_t           event_res;
    logic [OpW-1:0]   frame_opcode;
    logic             final_fragment;
    logic [ByteW-1:0] payload_byte;
    logic             last_of_frame;
  } wsd_res_t;

endpackage
`default_nettype wire

[design/websocket_frame_deframer_core.sv]
// Top level of the websocket receive deframer: input stage, parser, result stage.
// A byte accepted on s_* reaches m_* through the input register and the result register.
// Throughput: one byte per cycle while m_* is not stalled; the last reason byte of a close
// frame gives two results and holds the parser until the held closed event goes out.
// Reset (rst, synchronous, active high) clears the parser and both stages; after a
// close or error every byte is sunk without a result until the next reset.
`default_nettype none
module websocket_frame_deframer_core import wsd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  // input stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] rx_byte
  // result stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,   // [7:0] payload_byte
  output logic [7:0]            m_tuser,   // [2:0] event_res, [6:3] frame_opcode,
                                           // [7] final_fragment
  output logic                  m_tlast    // last_of_frame
);

  // input register
  logic             in_valid;
  logic [ByteW-1:0] in_byte;

  // result register and the held second result (closed event)
  wsd_res_t out_res;
  wsd_res_t pend;

  wsd_res_t res0, res1;
  logic     out_free;
  logic     adv;

  // the result slot frees when empty or when its beat is taken
  assign out_free = !m_tvalid || m_tready;
  // parser steps only when its results have a place to go
  assign adv      = in_valid && out_free && !pend.valid;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  wsd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .rx_byte (in_byte),
    .res0    (res0),
    .res1    (res1)
  );

  // result stage: a held closed event goes out first, parser output next
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend.valid <= 1'b0;
    end else if (out_free) begin
      if (pend.valid) begin
        m_tvalid   <= 1'b1;
        out_res    <= pend;
        pend.valid <= 1'b0;
      end else if (adv && res0.valid) begin
        m_tvalid <= 1'b1;
        out_res  <= res0;
        pend     <= res1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = out_res.payload_byte;
  assign m_tuser = {out_res.final_fragment, out_res.frame_opcode, out_res.event_res};
  assign m_tlast = out_res.last_of_frame;

endmodule
`default_nettype wire

[design/wsd_parse.sv]
// Header/payload parser: state registers plus one-beat result decode.
`default_nettype none
module wsd_parse import wsd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,       // consume rx_byte this cycle
  input  wire logic [ByteW-1:0] rx_byte,
  output wsd_res_t              res0,
  output wsd_res_t              res1       // only ever a closed event
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_STOPPED = 3'd4
  } phase_t;

  phase_t             phase, phase_next;
  logic [OpW-1:0]     opcode, opcode_next;
  logic               fin, fin_next;
  logic [LenCntW-1:0] len_left, len_left_next;
  logic [LenW-1:0]    remaining, remaining_next;
  logic [SkipW-1:0]   skip, skip_next;

  logic [LenW-1:0]    len_cand;
  logic               start;
  logic               op_known;
  logic               rem_is_one;

  always_comb begin
    op_known = (opcode == OP_CONT) || (opcode == OP_TEXT) || (opcode == OP_BINARY) ||
               (opcode == OP_CLOSE) || (opcode == OP_PING) || (opcode == OP_PONG);
  end

  assign rem_is_one = (remaining == LenW'(1));

  function automatic wsd_res_t mk_res(event_t ev, logic [OpW-1:0] op, logic f,
                                      logic [ByteW-1:0] b, logic last);
    wsd_res_t r;
    r.valid          = 1'b1;
    r.event_res      = ev;
    r.frame_opcode   = op;
    r.final_fragment = f;
    r.payload_byte   = b;
    r.last_of_frame  = last;
    return r;
  endfunction

  always_comb begin
    phase_next     = phase;
    opcode_next    = opcode;
    fin_next       = fin;
    len_left_next  = len_left;
    remaining_next = remaining;
    skip_next      = skip;
    res0           = '0;
    res1           = '0;
    len_cand       = '0;
    start          = 1'b0;

    unique case (phase)
      PH_HDR0: begin
        fin_next    = rx_byte[7];
        opcode_next = rx_byte[OpW-1:0];
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        if (rx_byte[7]) begin
          res0       = mk_res(EV_MASKED, opcode, fin, '0, 1'b0);
          phase_next = PH_STOPPED;
        end else if (!op_known) begin
          res0       = mk_res(EV_BADOP, opcode, fin, '0, 1'b0);
          phase_next = PH_STOPPED;
        end else begin
          remaining_next = '0;
          skip_next      = '0;
          if (rx_byte[6:0] == Len7Ext16) begin
            len_left_next = ExtBytes16;
            phase_next    = PH_EXTLEN;
          end else if (rx_byte[6:0] == Len7Ext64) begin
            len_left_next = ExtBytes64;
            phase_next    = PH_EXTLEN;
          end else begin
            len_cand = LenW'(rx_byte[6:0]);
            start    = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        len_cand       = {remaining[LenW-ByteW-1:0], rx_byte};
        remaining_next = len_cand;
        if (len_left != '0) len_left_next = len_left - LenCntW'(1);
        start = (len_left_next == '0);
      end
      PH_PAYLOAD: begin
        if (remaining == '0) begin
          phase_next = PH_HDR0;
        end else begin
          remaining_next = remaining - LenW'(1);
          if (opcode == OP_CLOSE) begin
            if (skip != '0) begin
              skip_next = skip - SkipW'(1);
              if (rem_is_one) begin
                res0       = mk_res(EV_CLOSED, opcode, fin, '0, 1'b0);
                phase_next = PH_STOPPED;
              end
            end else begin
              res0 = mk_res(EV_DATA, opcode, fin, rx_byte, rem_is_one);
              if (rem_is_one) begin
                res1       = mk_res(EV_CLOSED, opcode, fin, '0, 1'b0);
                phase_next = PH_STOPPED;
              end
            end
          end else begin
            res0 = mk_res(EV_DATA, opcode, fin, rx_byte, rem_is_one);
            if (rem_is_one) phase_next = PH_HDR0;
          end
        end
      end
      default: phase_next = PH_STOPPED;
    endcase

    // length now known: decide how the payload starts
    if (start) begin
      remaining_next = len_cand;
      if (opcode == OP_CLOSE) begin
        if (len_cand == '0) begin
          res0       = mk_res(EV_CLOSED, opcode, fin, '0, 1'b0);
          phase_next = PH_STOPPED;
        end else begin
          skip_next  = (len_cand >= LenW'(StatusBytes)) ? StatusBytes : SkipW'(1);
          phase_next = PH_PAYLOAD;
        end
      end else if (len_cand == '0) begin
        res0       = mk_res(EV_EMPTY, opcode, fin, '0, 1'b0);
        phase_next = PH_HDR0;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      opcode    <= '0;
      fin       <= 1'b0;
      len_left  <= '0;
      remaining <= '0;
      skip      <= '0;
    end else if (adv) begin
      phase     <= phase_next;
      opcode    <= opcode_next;
      fin       <= fin_next;
      len_left  <= len_left_next;
      remaining <= remaining_next;
      skip      <= skip_next;
    end
  end

endmodule
`default_nettype wire

[tb/tb_websocket_frame_deframer_core.sv]
// Self-checking stream testbench for the websocket receive deframer core.
`timescale 1ns / 100ps

module tb_websocket_frame_deframer_core;
  import wsd_pkg::*;

  localparam int unsigned QuietLimit  = 2000;  // cycles with no beat on either side
  localparam int unsigned BacklogAt   = 200;   // input beats before the long output hold
  localparam int unsigned BacklogLen  = 300;   // length of that hold, in cycles
  localparam int unsigned SteadyFrom  = 400;   // window of input beats with no gaps
  localparam int unsigned SteadyTo    = 600;
  localparam int unsigned StreamBytes = 1000;
  localparam int unsigned LongCap     = 40;    // bytes sent of a frame too long to finish

  // parser phase of the predictor
  typedef enum logic [2:0] {
    ST_HDR0,
    ST_HDR1,
    ST_EXTLEN,
    ST_PAYLOAD,
    ST_STOPPED
  } parse_state_t;

  // form of the length field when building a frame
  typedef enum int unsigned {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_t;

  typedef struct packed {
    event_t     ev;
    logic [3:0] opcode;
    logic       fin;
    logic [7:0] data;
    logic       last;
  } deframe_res_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [7:0] m_tuser;
  logic       m_tlast;

  // stimulus and scoreboard
  logic [7:0]   wire_bytes_q[$];   // bytes still to be offered on s_*
  deframe_res_t deframed_q[$];     // results expected on m_*, oldest first
  int unsigned  bytes_in       = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  backlog_left   = 0;
  bit           backlog_done   = 1'b0;

  // predictor state
  parse_state_t rx_state   = ST_HDR0;
  logic [3:0]   cur_op     = '0;
  logic         cur_fin    = 1'b0;
  logic [3:0]   ext_left   = '0;
  logic [63:0]  frame_left = '0;
  logic [1:0]   skip_left  = '0;

  always #10 clk = ~clk;

  websocket_frame_deframer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // Predictor: one call per accepted input beat, pushes 0..2 expected results.
  // ---------------------------------------------------------------------------
  function automatic void push_result(event_t ev, logic [7:0] data, logic last);
    deframe_res_t r;
    r.ev     = ev;
    r.opcode = cur_op;
    r.fin    = cur_fin;
    r.data   = data;
    r.last   = last;
    deframed_q.push_back(r);
  endfunction

  function automatic bit opcode_known(logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
           op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  // length is known: empty frame, close bookkeeping or on to payload
  function automatic void begin_payload();
    if (cur_op == OP_CLOSE) begin
      if (frame_left == 0) begin
        push_result(EV_CLOSED, 8'h00, 1'b0);
        rx_state = ST_STOPPED;
      end else begin
        // status code is two bytes; a one-byte close payload is all status
        skip_left = (frame_left >= 2) ? StatusBytes : 2'd1;
        rx_state  = ST_PAYLOAD;
      end
    end else if (frame_left == 0) begin
      push_result(EV_EMPTY, 8'h00, 1'b0);
      rx_state = ST_HDR0;
    end else begin
      rx_state = ST_PAYLOAD;
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    case (rx_state)
      ST_HDR0: begin
        // RSV bits are ignored
        cur_fin  = b[7];
        cur_op   = b[3:0];
        rx_state = ST_HDR1;
      end
      ST_HDR1: begin
        if (b[7]) begin
          // masked frame wins over a bad opcode
          push_result(EV_MASKED, 8'h00, 1'b0);
          rx_state = ST_STOPPED;
        end else if (!opcode_known(cur_op)) begin
          push_result(EV_BADOP, 8'h00, 1'b0);
          rx_state = ST_STOPPED;
        end else begin
          frame_left = '0;
          skip_left  = '0;
          if (b[6:0] == Len7Ext16) begin
            ext_left = ExtBytes16;
            rx_state = ST_EXTLEN;
          end else if (b[6:0] == Len7Ext64) begin
            ext_left = ExtBytes64;
            rx_state = ST_EXTLEN;
          end else begin
            frame_left = {57'd0, b[6:0]};
            begin_payload();
          end
        end
      end
      ST_EXTLEN: begin
        // big-endian, all 64 bits taken as sent
        frame_left = {frame_left[55:0], b};
        if (ext_left != 0) ext_left = ext_left - 1'b1;
        if (ext_left == 0) begin_payload();
      end
      ST_PAYLOAD: begin
        if (frame_left == 0) begin
          rx_state = ST_HDR0;
        end else begin
          frame_left = frame_left - 1'b1;
          if (cur_op == OP_CLOSE && skip_left != 0) begin
            skip_left = skip_left - 1'b1;
            if (frame_left == 0) begin
              push_result(EV_CLOSED, 8'h00, 1'b0);
              rx_state = ST_STOPPED;
            end
          end else begin
            push_result(EV_DATA, b, frame_left == 0);
            if (frame_left == 0) begin
              if (cur_op == OP_CLOSE) begin
                // last reason byte: data beat then the closed event
                push_result(EV_CLOSED, 8'h00, 1'b0);
                rx_state = ST_STOPPED;
              end else begin
                rx_state = ST_HDR0;
              end
            end
          end
        end
      end
      default: rx_state = ST_STOPPED;  // everything sunk until reset
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------
  // Unmasked frame with random RSV and payload. A length too big to send in
  // full only gets a short run of payload bytes; such a frame ends the stream.
  function automatic void queue_frame(logic fin, logic [3:0] op, logic [63:0] len,
                                      len_form_t form);
    logic [63:0] send_n;
    send_n = (len > 64'd65535) ? 64'(LongCap) : len;
    wire_bytes_q.push_back({fin, 3'($urandom), op});
    case (form)
      LEN_SHORT: wire_bytes_q.push_back({1'b0, len[6:0]});
      LEN_EXT16: begin
        wire_bytes_q.push_back({1'b0, Len7Ext16});
        wire_bytes_q.push_back(len[15:8]);
        wire_bytes_q.push_back(len[7:0]);
      end
      default: begin
        wire_bytes_q.push_back({1'b0, Len7Ext64});
        for (int i = 7; i >= 0; i--) wire_bytes_q.push_back(len[8*i +: 8]);
      end
    endcase
    for (longint unsigned i = 0; i < send_n; i++)
      wire_bytes_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic logic [3:0] pick_data_op();
    case ($urandom_range(4))
      0:       return OP_CONT;
      1:       return OP_TEXT;
      2:       return OP_BINARY;
      3:       return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  // gaps on both sides, except inside the steady window
  function automatic bit roll_gap();
    if (bytes_in >= SteadyFrom && bytes_in < SteadyTo) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sel;
    int unsigned v;
    logic [3:0]  bad_op;

    // directed: empty frame, byte extremes, every data opcode, RSV set,
    // non-minimal 16- and 64-bit lengths
    queue_frame(1'b1, OP_TEXT,   64'd0, LEN_SHORT);
    wire_bytes_q.push_back({1'b1, 3'b111, OP_BINARY});
    wire_bytes_q.push_back(8'h01);
    wire_bytes_q.push_back(8'hFF);
    wire_bytes_q.push_back({1'b0, 3'b000, OP_CONT});
    wire_bytes_q.push_back(8'h01);
    wire_bytes_q.push_back(8'h00);
    queue_frame(1'b1, OP_PING,   64'd2, LEN_SHORT);
    queue_frame(1'b1, OP_PONG,   64'd0, LEN_SHORT);
    queue_frame(1'b1, OP_TEXT,   64'd0, LEN_EXT16);
    queue_frame(1'b0, OP_BINARY, 64'd1, LEN_EXT64);

    // length boundaries around the short form
    queue_frame(1'b1, pick_data_op(), 64'd125, LEN_SHORT);
    queue_frame(1'b1, pick_data_op(), 64'd126, LEN_EXT16);

    // random well-formed frames, mostly short
    while (wire_bytes_q.size() < StreamBytes) begin
      sel = $urandom_range(99);
      if (sel < 70)
        queue_frame(1'($urandom), pick_data_op(), 64'($urandom_range(8)), LEN_SHORT);
      else if (sel < 85)
        queue_frame(1'($urandom), pick_data_op(), 64'($urandom_range(125, 9)), LEN_SHORT);
      else if (sel < 95)
        queue_frame(1'($urandom), pick_data_op(), 64'($urandom_range(300)), LEN_EXT16);
      else
        queue_frame(1'($urandom), pick_data_op(), 64'($urandom_range(300)), LEN_EXT64);
    end

    // One terminating case per run, since the block only recovers by reset.
    case ($urandom_range(6))
      0: begin  // masked frame, any opcode
        wire_bytes_q.push_back(8'($urandom_range(255)));
        wire_bytes_q.push_back({1'b1, 7'($urandom)});
      end
      1: begin  // unknown opcode
        v      = $urandom_range(9);
        bad_op = (v < 5) ? 4'(v + 3) : 4'(v + 6);
        wire_bytes_q.push_back({1'($urandom), 3'($urandom), bad_op});
        wire_bytes_q.push_back({1'b0, 7'($urandom_range(125))});
      end
      2: queue_frame(1'b1, OP_CLOSE, 64'd0, LEN_SHORT);
      3: queue_frame(1'b1, OP_CLOSE, 64'd1, LEN_SHORT);
      4: queue_frame(1'b1, OP_CLOSE, 64'd2, LEN_SHORT);
      5: queue_frame(1'b1, OP_CLOSE, 64'($urandom_range(20, 3)),
                     $urandom_range(1) ? LEN_EXT16 : LEN_SHORT);
      default:  // 64-bit length with the top bit set, never finished
        queue_frame(1'($urandom), pick_data_op(),
                    {1'b1, 31'($urandom), 32'($urandom)}, LEN_EXT64);
    endcase
    // bytes after a close or error must vanish
    repeat (16) wire_bytes_q.push_back(8'($urandom_range(255)));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (wire_bytes_q.size() != 0 || s_tvalid) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_websocket_frame_deframer_core: PASS");
    end else begin
      $display("tb_websocket_frame_deframer_core: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers the queued bytes, predicts on each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        deframe_byte(s_tdata);
        bytes_in <= bytes_in + 1;
      end
      // a held beat stays put until taken
      if (!s_tvalid || s_tready) begin
        if (wire_bytes_q.size() != 0 && !roll_gap()) begin
          s_tvalid <= 1'b1;
          s_tdata  <= wire_bytes_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random gaps plus one long hold to back the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!backlog_done && bytes_in >= BacklogAt) begin
      backlog_done <= 1'b1;
      backlog_left <= BacklogLen;
      m_tready     <= 1'b0;
    end else if (backlog_left != 0) begin
      backlog_left <= backlog_left - 1;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= !roll_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    deframe_res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (deframed_q.size() == 0) begin
        $error("result beat with nothing expected: tuser %0h tdata %0h tlast %0b",
               m_tuser, m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        exp_r = deframed_q.pop_front();
        check_field("event_res",      8'(exp_r.ev),     8'(m_tuser[2:0]));
        check_field("frame_opcode",   8'(exp_r.opcode), 8'(m_tuser[6:3]));
        check_field("final_fragment", 8'(exp_r.fin),    8'(m_tuser[7]));
        check_field("payload_byte",   exp_r.data,       m_tdata);
        check_field("last_of_frame",  8'(exp_r.last),   8'(m_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no beat on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $error("no progress for %0d cycles, %0d results outstanding",
             QuietLimit, deframed_q.size());
      $display("tb_websocket_frame_deframer_core: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
